// ===== rtl/stp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared codes and the controller/datapath command and status types of the
// segment table position lookup block.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int FIELD_W     = 32;
	localparam int REQ_W       = 2;
	localparam int SEG_INDEX_W = 10;
	localparam int STATUS_W    = 2;

	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Source of the result captured by the datapath.
	typedef enum logic [2:0] {
		RES_OK      = 3'd0,
		RES_FULL    = 3'd1,
		RES_EMPTY   = 3'd2,
		RES_MID     = 3'd3,
		RES_EXHAUST = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     start;
		logic     clear;
		logic     append;
		logic     rd_en;
		logic     rd_next;
		logic     save_tag;
		logic     go_left;
		logic     go_right;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic window_open;
		logic below;
		logic past_end;
		logic at_end;
		logic next_differs;
	} sts_t;

endpackage

// ===== rtl/stp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_datapath
// Segment memory, entry count, search window registers, comparators and the
// result and output registers.
// ----------------------------------------------------------------------------
module stp_datapath #(
	parameter int TABLE_DEPTH = 1024,
	parameter int POS_BITS    = 32,
	parameter int TAG_BITS    = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  stp_pkg::cmd_t                    cmd,
	output stp_pkg::sts_t                    sts,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_start,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_end,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_tag,
	input  logic [stp_pkg::FIELD_W-1:0]      lookup_pos,
	output logic [stp_pkg::SEG_INDEX_W-1:0]  seg_index,
	output logic [stp_pkg::STATUS_W-1:0]     status
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = TAG_BITS + 2 * POS_BITS;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [POS_BITS-1:0] pos_q;
	logic [TAG_BITS-1:0] tag_mid_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [stp_pkg::STATUS_W-1:0]    res_status_q;
	logic [stp_pkg::SEG_INDEX_W-1:0] seg_index_q;
	logic [stp_pkg::STATUS_W-1:0]    status_q;

	logic [CNT_W-1:0]    span;
	logic [CNT_W-1:0]    mid;
	logic [CNT_W-1:0]    mid_inc;
	logic [CNT_W-1:0]    count_m1;
	logic [IDX_W-1:0]    rd_addr;
	logic [POS_BITS-1:0] rd_start;
	logic [POS_BITS-1:0] rd_end;
	logic [TAG_BITS-1:0] rd_tag;
	logic [IDX_W-1:0]    exhaust_idx;

	assign span     = hi_q - lo_q;
	assign mid      = lo_q + (span >> 1);
	assign mid_inc  = mid + CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);
	assign rd_addr  = cmd.rd_next ? mid_inc[IDX_W-1:0] : mid[IDX_W-1:0];

	assign rd_start = rd_q[POS_BITS-1:0];
	assign rd_end   = rd_q[2*POS_BITS-1:POS_BITS];
	assign rd_tag   = rd_q[ENTRY_W-1:2*POS_BITS];

	// The window never runs past the count, so lo is the only candidate
	// unless it has reached the entry count.
	assign exhaust_idx = (lo_q < count_q) ? lo_q[IDX_W-1:0] : count_m1[IDX_W-1:0];

	always_comb begin
		sts.empty        = (count_q == '0);
		sts.full         = (count_q >= CNT_W'(TABLE_DEPTH));
		sts.window_open  = (lo_q < hi_q);
		sts.below        = (pos_q < rd_start);
		sts.past_end     = (pos_q >= rd_end) && (mid_inc < count_q);
		sts.at_end       = (pos_q == rd_end);
		sts.next_differs = (rd_tag != tag_mid_q) && (rd_start != pos_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[count_q[IDX_W-1:0]] <= {TAG_BITS'(seg_tag), POS_BITS'(seg_end),
				POS_BITS'(seg_start)};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				lo_q <= '0;
				hi_q <= count_q;
			end else if (cmd.go_left) begin
				hi_q <= mid;
			end else if (cmd.go_right) begin
				lo_q <= mid_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= POS_BITS'(lookup_pos);
		end
		if (cmd.save_tag) begin
			tag_mid_q <= rd_tag;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				stp_pkg::RES_FULL: begin
					res_idx_q    <= '0;
					res_status_q <= stp_pkg::STATUS_FULL;
				end
				stp_pkg::RES_EMPTY: begin
					res_idx_q    <= '0;
					res_status_q <= stp_pkg::STATUS_EMPTY;
				end
				stp_pkg::RES_MID: begin
					res_idx_q    <= mid[IDX_W-1:0];
					res_status_q <= stp_pkg::STATUS_OK;
				end
				stp_pkg::RES_EXHAUST: begin
					res_idx_q    <= exhaust_idx;
					res_status_q <= stp_pkg::STATUS_OK;
				end
				default: begin
					res_idx_q    <= '0;
					res_status_q <= stp_pkg::STATUS_OK;
				end
			endcase
		end
		if (cmd.out_load) begin
			seg_index_q <= stp_pkg::SEG_INDEX_W'(res_idx_q);
			status_q    <= res_status_q;
		end
	end

	assign seg_index = seg_index_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_window_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search window lower bound passed upper bound");

	a_append_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (count_q < CNT_W'(TABLE_DEPTH)))
		else $error("append issued on a full table");
`endif

endmodule

// ===== rtl/stp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_ctrl
// Request sequencer: decodes requests, steps the binary search one probe at a
// time and hands results to the output register.
// ----------------------------------------------------------------------------
module stp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [stp_pkg::REQ_W-1:0]     req_type,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output stp_pkg::cmd_t                 cmd,
	input  stp_pkg::sts_t                 sts
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PROBE  = 6'b000010,
		S_CHECK  = 6'b000100,
		S_NCHECK = 6'b001000,
		S_FINISH = 6'b010000,
		S_SPARE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start    = 1'b1;
					cmd.res_load = 1'b1;
					state_d      = S_FINISH;
					case (req_type)
						stp_pkg::REQ_CLEAR: begin
							cmd.clear   = 1'b1;
							cmd.res_sel = stp_pkg::RES_OK;
						end
						stp_pkg::REQ_APPEND: begin
							if (sts.full) begin
								cmd.res_sel = stp_pkg::RES_FULL;
							end else begin
								cmd.append  = 1'b1;
								cmd.res_sel = stp_pkg::RES_OK;
							end
						end
						stp_pkg::REQ_LOOKUP: begin
							if (sts.empty) begin
								cmd.res_sel = stp_pkg::RES_EMPTY;
							end else begin
								cmd.res_load = 1'b0;
								state_d      = S_PROBE;
							end
						end
						default: begin
							cmd.res_sel = stp_pkg::RES_OK;
						end
					endcase
				end
			end
			S_PROBE: begin
				if (sts.window_open) begin
					cmd.rd_en = 1'b1;
					state_d   = S_CHECK;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = stp_pkg::RES_EXHAUST;
					state_d      = S_FINISH;
				end
			end
			S_CHECK: begin
				if (sts.below) begin
					cmd.go_left = 1'b1;
					state_d     = S_PROBE;
				end else if (sts.past_end) begin
					// Exactly at the end: the neighbor decides whether the
					// position stays in this segment.
					if (sts.at_end) begin
						cmd.rd_en    = 1'b1;
						cmd.rd_next  = 1'b1;
						cmd.save_tag = 1'b1;
						state_d      = S_NCHECK;
					end else begin
						cmd.go_right = 1'b1;
						state_d      = S_PROBE;
					end
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = stp_pkg::RES_MID;
					state_d      = S_FINISH;
				end
			end
			S_NCHECK: begin
				if (sts.next_differs) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = stp_pkg::RES_MID;
					state_d      = S_FINISH;
				end else begin
					cmd.go_right = 1'b1;
					state_d      = S_PROBE;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_check_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> ($past(state_q) == S_PROBE))
		else $error("compare state entered without a memory probe");

	a_neighbor_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NCHECK) |-> $past(cmd.rd_next))
		else $error("neighbor compare without a neighbor read");

	a_empty_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid && req_type == stp_pkg::REQ_LOOKUP && sts.empty)
		|=> (state_q == S_FINISH))
		else $error("lookup on empty table started a search");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/segment_table_position_lookup.sv =====
`timescale 1ns / 1ps
// Sequence: clear, append and an empty-table lookup load the result register on acceptance;
// other lookups run probes (at most clog2(count)+1, each a read on the one registered read
// port and a compare) and neighbor reads at segment ends before loading it. The result then
// moves to the output register once that is free. The next request is taken the cycle after
// the result moves to the output register, which holds it during a stall.
// Reset: the entry count clears at once; segment memory is not cleared.
// ----------------------------------------------------------------------------
// segment_table_position_lookup
// Ordered segment table with clear, append and binary-search lookup requests.
// ----------------------------------------------------------------------------
module segment_table_position_lookup #(
	parameter int TABLE_DEPTH = 1024,
	parameter int POS_BITS    = 32,
	parameter int TAG_BITS    = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [stp_pkg::REQ_W-1:0]        req_type,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_start,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_end,
	input  logic [stp_pkg::FIELD_W-1:0]      seg_tag,
	input  logic [stp_pkg::FIELD_W-1:0]      lookup_pos,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [stp_pkg::SEG_INDEX_W-1:0]  seg_index,
	output logic [stp_pkg::STATUS_W-1:0]     status
);

	stp_pkg::cmd_t cmd;
	stp_pkg::sts_t sts;

	stp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	stp_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.POS_BITS    (POS_BITS),
		.TAG_BITS    (TAG_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.seg_start  (seg_start),
		.seg_end    (seg_end),
		.seg_tag    (seg_tag),
		.lookup_pos (lookup_pos),
		.seg_index  (seg_index),
		.status     (status)
	);

endmodule
